// ===== src/lmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Lamp matrix state controller package
// Shared constants, operation codes and word types for the lamp controller.
// ----------------------------------------------------------------------------
package lmsc_pkg;

    localparam int unsigned LAMP_COUNT = 64;
    localparam int unsigned SET_W      = 64;
    localparam int unsigned IDX_W      = 6;
    localparam int unsigned OP_W       = 4;

    localparam logic [IDX_W:0] LAMP_LIMIT = (IDX_W + 1)'(LAMP_COUNT);
    localparam logic [SET_W-1:0] FULL_MASK =
        (LAMP_COUNT >= SET_W) ? {SET_W{1'b1}}
                              : ((SET_W'(1) << LAMP_COUNT) - SET_W'(1));

    typedef enum logic [OP_W-1:0] {
        OP_ON        = 4'd0,
        OP_OFF       = 4'd1,
        OP_TOGGLE    = 4'd2,
        OP_TEST      = 4'd3,
        OP_FLASH_ON  = 4'd4,
        OP_FLASH_OFF = 4'd5,
        OP_FLASH_TST = 4'd6,
        OP_FX_ON     = 4'd7,
        OP_FX_OFF    = 4'd8,
        OP_FX_TOGGLE = 4'd9,
        OP_FX_TEST   = 4'd10,
        OP_ALL_ON    = 4'd11,
        OP_ALL_OFF   = 4'd12,
        OP_TICK      = 4'd13
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]  req_type;
        logic [IDX_W-1:0] lamp_index;
    } req_word_t;

    typedef struct packed {
        logic             test_bit;
        logic [SET_W-1:0] steady_out;
        logic [SET_W-1:0] enable_out;
        logic [SET_W-1:0] phase_out;
        logic [SET_W-1:0] effect_out;
    } rsp_word_t;

endpackage

// ===== src/lmsc_lamp_core.sv =====
// ----------------------------------------------------------------------------
// Lamp set core
// Holds the four lamp sets and applies one operation word per fire cycle.
// ----------------------------------------------------------------------------
module lmsc_lamp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  lmsc_pkg::req_word_t cmd,
    output lmsc_pkg::rsp_word_t rsp_next
);
    import lmsc_pkg::*;

    logic [SET_W-1:0] steady_reg;
    logic [SET_W-1:0] enable_reg;
    logic [SET_W-1:0] phase_reg;
    logic [SET_W-1:0] effect_reg;
    logic [SET_W-1:0] steady_next;
    logic [SET_W-1:0] enable_next;
    logic [SET_W-1:0] phase_next;
    logic [SET_W-1:0] effect_next;
    logic [SET_W-1:0] lamp_bit;
    logic             lamp_valid;
    logic             test_next;

    assign lamp_valid = {1'b0, cmd.lamp_index} < LAMP_LIMIT;
    assign lamp_bit   = lamp_valid ? (SET_W'(1) << cmd.lamp_index) : '0;

    always_comb
    begin
        steady_next = steady_reg;
        enable_next = enable_reg;
        phase_next  = phase_reg;
        effect_next = effect_reg;
        test_next   = 1'b0;
        case (op_t'(cmd.req_type))
            OP_ON:        steady_next = steady_reg | lamp_bit;
            OP_OFF:       steady_next = steady_reg & ~lamp_bit;
            OP_TOGGLE:    steady_next = steady_reg ^ lamp_bit;
            OP_TEST:      test_next   = (steady_reg & lamp_bit) != '0;
            OP_FLASH_ON:
            begin
                if ((lamp_bit != '0) && ((enable_reg & lamp_bit) == '0))
                begin
                    enable_next = enable_reg | lamp_bit;
                    if (phase_reg != '0)
                    begin
                        phase_next = phase_reg | lamp_bit;
                    end
                    else
                    begin
                        phase_next = phase_reg & ~lamp_bit;
                    end
                end
            end
            OP_FLASH_OFF:
            begin
                enable_next = enable_reg & ~lamp_bit;
                phase_next  = phase_reg & ~lamp_bit;
            end
            OP_FLASH_TST: test_next   = (enable_reg & lamp_bit) != '0;
            OP_FX_ON:     effect_next = effect_reg | lamp_bit;
            OP_FX_OFF:    effect_next = effect_reg & ~lamp_bit;
            OP_FX_TOGGLE: effect_next = effect_reg ^ lamp_bit;
            OP_FX_TEST:   test_next   = (effect_reg & lamp_bit) != '0;
            OP_ALL_ON:
            begin
                enable_next = '0;
                steady_next = FULL_MASK;
            end
            OP_ALL_OFF:
            begin
                steady_next = '0;
                enable_next = '0;
                phase_next  = '0;
                effect_next = '0;
            end
            OP_TICK:      phase_next  = phase_reg ^ enable_reg;
            default:
            begin
                test_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steady_reg <= '0;
            enable_reg <= '0;
            phase_reg  <= '0;
            effect_reg <= '0;
        end
        else if (fire)
        begin
            steady_reg <= steady_next;
            enable_reg <= enable_next;
            phase_reg  <= phase_next;
            effect_reg <= effect_next;
        end
    end

    assign rsp_next.test_bit   = test_next;
    assign rsp_next.steady_out = steady_next;
    assign rsp_next.enable_out = enable_next;
    assign rsp_next.phase_out  = phase_next;
    assign rsp_next.effect_out = effect_next;

endmodule

// ===== src/lamp_matrix_state_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Lamp matrix state controller
// Keeps steady, flash enable, flash phase and effect sets for a lamp matrix.
//
// The request channel (req_valid, req_stall, req) carries one operation word
// with its lamp index. The response channel (rsp_valid, rsp_stall, rsp)
// returns exactly one word per request: the tested bit and all four lamp
// sets as they stand after the operation.
// A request is captured in an input register, applied to the lamp sets by
// one level of logic and written to the response register. One request is
// taken in every cycle while the response side keeps up.
// When the receiver stalls, the response word holds; the input register
// still takes one more request, and req_stall rises once both registers
// are full. Reset clears all four lamp sets and empties both registers.
// ----------------------------------------------------------------------------
module lamp_matrix_state_controller_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lmsc_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lmsc_pkg::rsp_word_t rsp
);
    import lmsc_pkg::*;

    req_word_t req_reg;
    logic      req_valid_reg;
    rsp_word_t rsp_reg;
    logic      rsp_valid_reg;
    rsp_word_t rsp_next;
    logic      rsp_free;
    logic      fire;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && rsp_free;
    assign req_stall = req_valid_reg && !rsp_free;

    lmsc_lamp_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cmd      (req_reg),
        .rsp_next (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                req_valid_reg <= req_valid;
            end
            if (rsp_free)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/lmsc_checker.sv =====
// ----------------------------------------------------------------------------
// Lamp matrix state controller checker
// Port-level checks on flow control and response timing, bound to the top.
// ----------------------------------------------------------------------------
module lmsc_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input lmsc_pkg::req_word_t req,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input lmsc_pkg::rsp_word_t rsp
);
    import lmsc_pkg::*;

    // An accepted request is always followed by a valid response word.
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> ##1 rsp_valid)
        else $error("no response after accepted request");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled while response side is free");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(rsp))
        else $error("response word changed while stalled");

    a_req_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_stall) |=> (req_valid && $stable(req)))
        else $error("request word changed while stalled");

endmodule

bind lamp_matrix_state_controller_unit lmsc_checker u_lmsc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
